// File: rtl/rac_pkg.sv
// Package with shared types, constants and command structs of the radix accumulator calculator.
package rac_pkg;

  localparam int unsigned AccWidth  = 64;
  localparam int unsigned MaxDigits = 64;
  localparam int unsigned DigIdxW   = $clog2(MaxDigits);
  localparam int unsigned DigCntW   = $clog2(MaxDigits + 1);
  localparam int unsigned AccCntW   = $clog2(AccWidth + 1);

  localparam logic [3:0] OpClear = 4'd0;
  localparam logic [3:0] OpShow  = 4'd1;
  localparam logic [3:0] OpRadix = 4'd2;
  localparam logic [3:0] OpDigit = 4'd3;
  localparam logic [3:0] OpAdd   = 4'd4;
  localparam logic [3:0] OpSub   = 4'd5;
  localparam logic [3:0] OpMul   = 4'd6;
  localparam logic [3:0] OpDiv   = 4'd7;
  localparam logic [3:0] OpMod   = 4'd8;

  localparam logic [2:0] PendNone = 3'd0;
  localparam logic [2:0] PendAdd  = 3'd1;
  localparam logic [2:0] PendSub  = 3'd2;
  localparam logic [2:0] PendMul  = 3'd3;
  localparam logic [2:0] PendDiv  = 3'd4;
  localparam logic [2:0] PendMod  = 3'd5;

  localparam logic [6:0] CharZero = 7'd48;
  localparam logic [6:0] CharNine = 7'd57;
  localparam logic [6:0] CharA    = 7'd65;

  typedef struct packed {
    logic [3:0] opcode;
    logic [6:0] digit_char;
    logic       last_digit;
    logic [5:0] new_radix;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last;
    logic       empty_res;
    logic       error;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;   // latch the accepted item
    logic do_simple;   // clear, radix, operator, and the digit accumulate step
    logic mul_step;    // one step of the digit multiply (partial * radix)
    logic apply_start; // start applying the pending operation
    logic div_init;    // load the divider
    logic div_step;    // one bit of the divider
    logic apply_fin;   // finish a div or mod apply
    logic show_init;   // start the digit conversion
    logic show_fin;    // store one digit
    logic emit_init;   // set up digit read-out
    logic emit_next;   // move to the next digit
    logic cnv_next;    // restart the divider on the running quotient
    logic mpy_hl;      // product step: high accumulator half times low operand half
    logic mpy_lh;      // product step: low accumulator half times high operand half
    logic mpy_ll;      // product step: low halves
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       is_show;
    logic       is_digit;
    logic       is_last;
    logic       need_div;
    logic       need_mul;
    logic       div_by_zero;
    logic       div_done;
    logic       acc_neg;
    logic       acc_zero;
    logic       conv_done;
    logic       emit_last;
  } stat_t;

  function automatic logic [6:0] digit_to_char(input logic [5:0] d);
    logic [6:0] r;
    if (d < 6'd10) r = CharZero + {1'b0, d};
    else           r = CharA + {1'b0, d} - 7'd10;
    return r;
  endfunction

endpackage

// File: rtl/rac_datapath.sv
// Datapath of the radix accumulator calculator: registers, shared divider and digit store.
module rac_datapath import rac_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  item_i,
  input  cmd_t      cmd_i,
  output stat_t     stat_o,
  output out_item_t res_o
);

  in_item_t             item_q;
  logic [AccWidth-1:0]  acc_q, acc_d;
  logic [AccWidth-1:0]  part_q, part_d;
  logic [2:0]           pend_q, pend_d;
  logic [5:0]           radix_q, radix_d;
  logic                 err_q, err_d;

  // Shared restoring divider.
  logic [AccWidth-1:0]  dq_q;      // dividend shifting into quotient
  logic [AccWidth-1:0]  rem_q;
  logic [AccWidth-1:0]  dvs_q;
  logic [AccCntW-1:0]   dcnt_q;
  logic                 na_q, nb_q;
  logic [AccWidth:0]    rem_sh;
  logic [AccWidth:0]    rem_sub;

  logic [5:0]           dmem [MaxDigits];
  logic [DigCntW-1:0]   nd_q;
  logic [DigCntW-1:0]   rd_q;
  logic [5:0]           rdata_q;

  logic [AccWidth-1:0]  dval;
  logic [AccWidth-1:0]  prod_q;

  // Half-width multiplier shared by the three product steps.
  logic [AccWidth/2-1:0] mop_a, mop_b;
  logic [AccWidth-1:0]   mres;

  function automatic logic [AccWidth-1:0] mag(input logic [AccWidth-1:0] v);
    return v[AccWidth-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    if (item_q.digit_char >= CharZero && item_q.digit_char <= CharNine)
      dval = AccWidth'(item_q.digit_char - CharZero);
    else
      dval = AccWidth'(item_q.digit_char) - AccWidth'(CharA) + AccWidth'(10);
  end

  assign rem_sh  = {rem_q, dq_q[AccWidth-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  assign mop_a = cmd_i.mpy_hl ? acc_q[AccWidth-1:AccWidth/2] : acc_q[AccWidth/2-1:0];
  assign mop_b = cmd_i.mpy_lh ? part_q[AccWidth-1:AccWidth/2] : part_q[AccWidth/2-1:0];
  assign mres  = AccWidth'(mop_a) * AccWidth'(mop_b);

  always_comb begin
    acc_d   = acc_q;
    part_d  = part_q;
    pend_d  = pend_q;
    radix_d = radix_q;
    err_d   = err_q;
    if (cmd_i.do_simple) begin
      unique case (item_q.opcode)
        OpClear: acc_d = '0;
        OpRadix: if (item_q.new_radix >= 6'd2 && item_q.new_radix <= 6'd36)
                   radix_d = item_q.new_radix;
        OpDigit: part_d = prod_q + dval;
        OpAdd, OpSub, OpMul, OpDiv, OpMod: pend_d = 3'(item_q.opcode - OpDigit);
        default: ;
      endcase
    end
    if (cmd_i.apply_start) begin
      part_d = '0;
      pend_d = PendNone;
      unique case (pend_q)
        PendAdd: acc_d = acc_q + part_q;
        PendSub: acc_d = acc_q - part_q;
        PendMul: acc_d = prod_q;
        PendDiv, PendMod: if (part_q == '0) err_d = 1'b1;
        default: acc_d = part_q;
      endcase
    end
    if (cmd_i.apply_fin) begin
      part_d = '0;
      pend_d = PendNone;
      if (pend_q == PendDiv) acc_d = (na_q != nb_q) ? (~dq_q + 1'b1) : dq_q;
      else                   acc_d = na_q ? (~rem_q + 1'b1) : rem_q;
    end
    if (cmd_i.show_fin) acc_d = acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      part_q  <= '0;
      pend_q  <= PendNone;
      radix_q <= 6'd10;
      err_q   <= 1'b0;
      dcnt_q  <= '0;
      nd_q    <= '0;
      rd_q    <= '0;
    end else begin
      acc_q   <= acc_d;
      part_q  <= part_d;
      pend_q  <= pend_d;
      radix_q <= radix_d;
      err_q   <= err_d;
      if (cmd_i.div_init || cmd_i.cnv_next) begin
        dcnt_q <= AccCntW'(AccWidth);
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q - 1'b1;
      end
      if (cmd_i.show_init) nd_q <= '0;
      else if (cmd_i.show_fin) nd_q <= nd_q + 1'b1;
      if (cmd_i.emit_init) rd_q <= nd_q - 1'b1;
      else if (cmd_i.emit_next) rd_q <= rd_q - 1'b1;
    end
  end

  // Divider operands: apply uses magnitudes of acc and part, show divides
  // the conversion value (held in dq) by the radix.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= item_i;
    if (cmd_i.mul_step) prod_q <= part_q * AccWidth'(radix_q);
    else if (cmd_i.mpy_hl) prod_q <= {mres[AccWidth/2-1:0], {(AccWidth/2){1'b0}}};
    else if (cmd_i.mpy_lh) prod_q <= prod_q + {mres[AccWidth/2-1:0], {(AccWidth/2){1'b0}}};
    else if (cmd_i.mpy_ll) prod_q <= prod_q + mres;
    if (cmd_i.div_init) begin
      rem_q <= '0;
      if (cmd_i.show_init) begin
        dq_q  <= acc_q;
        dvs_q <= AccWidth'(radix_q);
        na_q  <= 1'b0;
        nb_q  <= 1'b0;
      end else begin
        dq_q  <= mag(acc_q);
        dvs_q <= mag(part_q);
        na_q  <= acc_q[AccWidth-1];
        nb_q  <= part_q[AccWidth-1];
      end
    end else if (cmd_i.cnv_next) begin
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dq_q <= {dq_q[AccWidth-2:0], ~rem_sub[AccWidth]};
      rem_q <= rem_sub[AccWidth] ? rem_sh[AccWidth-1:0] : rem_sub[AccWidth-1:0];
    end
    if (cmd_i.show_fin) dmem[nd_q[DigIdxW-1:0]] <= rem_q[5:0];
    rdata_q <= dmem[cmd_i.emit_init ? DigIdxW'(nd_q - 1'b1)
                                    : DigIdxW'(cmd_i.emit_next ? rd_q - 1'b1 : rd_q)];
  end

  assign stat_o.is_show     = item_q.opcode == OpShow;
  assign stat_o.is_digit    = item_q.opcode == OpDigit;
  assign stat_o.is_last     = item_q.last_digit;
  assign stat_o.need_div    = pend_q == PendDiv || pend_q == PendMod;
  assign stat_o.need_mul    = pend_q == PendMul;
  assign stat_o.div_by_zero = part_q == '0;
  assign stat_o.div_done    = dcnt_q == '0;
  assign stat_o.acc_neg     = acc_q[AccWidth-1];
  assign stat_o.acc_zero    = acc_q == '0;
  assign stat_o.conv_done   = dq_q == '0 || nd_q == DigCntW'(MaxDigits);
  assign stat_o.emit_last   = rd_q == '0;

  // Result: the controller decides which form is valid.
  always_comb begin
    res_o.error = err_q;
    if (acc_q[AccWidth-1]) begin
      res_o.out_char = '0; res_o.last = 1'b1; res_o.empty_res = 1'b1;
    end else if (acc_q == '0) begin
      res_o.out_char = CharZero; res_o.last = 1'b1; res_o.empty_res = 1'b0;
    end else begin
      res_o.out_char = digit_to_char(rdata_q);
      res_o.last = rd_q == '0; res_o.empty_res = 1'b0;
    end
  end

endmodule

// File: rtl/rac_ctrl.sv
// Controller state machine of the radix accumulator calculator.
module rac_ctrl import rac_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SDec   = 4'd1;
  localparam logic [3:0] SMul   = 4'd2;
  localparam logic [3:0] SAdd   = 4'd3;
  localparam logic [3:0] SApply = 4'd4;
  localparam logic [3:0] SDivA  = 4'd5;
  localparam logic [3:0] SCnv   = 4'd6;
  localparam logic [3:0] SCnvD  = 4'd7;
  localparam logic [3:0] SEmitR = 4'd8;
  localparam logic [3:0] SEmit  = 4'd9;
  localparam logic [3:0] SOne   = 4'd10;
  localparam logic [3:0] SMulA  = 4'd11;
  localparam logic [3:0] SMulB  = 4'd12;

  logic [3:0] st_q, st_d;

  assign in_stall_o  = st_q != SIdle;
  assign out_valid_o = st_q == SEmit || st_q == SOne;

  always_comb begin
    st_d  = st_q;
    cmd_o = '0;
    unique case (st_q)
      SIdle: if (in_valid_i) begin
        cmd_o.load_item = 1'b1;
        st_d = SDec;
      end
      SDec: begin
        if (stat_i.is_show) begin
          if (stat_i.acc_neg || stat_i.acc_zero) st_d = SOne;
          else begin
            cmd_o.div_init = 1'b1; cmd_o.show_init = 1'b1; st_d = SCnv;
          end
        end else if (stat_i.is_digit) begin
          cmd_o.mul_step = 1'b1; st_d = SMul;
        end else begin
          cmd_o.do_simple = 1'b1; st_d = SIdle;
        end
      end
      SMul: begin
        cmd_o.do_simple = 1'b1;
        st_d = stat_i.is_last ? SAdd : SIdle;
      end
      SAdd: begin
        if (stat_i.need_div && !stat_i.div_by_zero) begin
          cmd_o.div_init = 1'b1; st_d = SDivA;
        end else if (stat_i.need_mul) begin
          cmd_o.mpy_hl = 1'b1; st_d = SMulA;
        end else begin
          cmd_o.apply_start = 1'b1; st_d = SIdle;
        end
      end
      SMulA: begin
        cmd_o.mpy_lh = 1'b1; st_d = SMulB;
      end
      SMulB: begin
        cmd_o.mpy_ll = 1'b1; st_d = SApply;
      end
      SDivA: begin
        if (stat_i.div_done) begin
          cmd_o.apply_fin = 1'b1; st_d = SIdle;
        end else cmd_o.div_step = 1'b1;
      end
      SApply: begin
        cmd_o.apply_start = 1'b1; st_d = SIdle;
      end
      SCnv: begin
        if (stat_i.div_done) begin
          cmd_o.show_fin = 1'b1; st_d = SCnvD;
        end else cmd_o.div_step = 1'b1;
      end
      SCnvD: begin
        if (stat_i.conv_done) begin
          cmd_o.emit_init = 1'b1; st_d = SEmitR;
        end else begin
          cmd_o.cnv_next = 1'b1; st_d = SCnv;
        end
      end
      SEmitR: st_d = SEmit;
      SEmit: if (!out_stall_i) begin
        if (stat_i.emit_last) st_d = SIdle;
        else cmd_o.emit_next = 1'b1;
      end
      SOne: if (!out_stall_i) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= SIdle;
    else         st_q <= st_d;
  end

endmodule

// File: rtl/radix_accumulator_calculator_core.sv
// Top level of the radix accumulator calculator.
// The block takes one command per input transfer on in_item_i (valid/stall)
// and returns show characters as output transfers on out_item_o.
// Commands are clear, show, set radix, number digit and the five operators.
// Digits build a number in the current radix; the digit marked last applies
// the pending operation to the 64-bit accumulator.
// A last digit with multiply pending runs three half-width product steps, and
// with divide or modulo pending it runs the one-bit-per-cycle restoring
// divider. Show runs that divider once per digit, then, after a read-out
// setup state, emits digits one per cycle while the receiver does not stall.
// The block takes one item at a time; in_stall_o is high while it works.
// A negative accumulator shows one character with empty_res set; zero
// shows a single '0'. Divide by zero sets the sticky error flag.
// Reset gives accumulator 0, radix ten, no pending operation, error clear.
// When the receiver stalls, the shown character holds until it is taken.
module radix_accumulator_calculator_core import rac_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  cmd_t  cmd;
  stat_t stat;

  // The controller sequences each command; the datapath does the work.
  rac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rac_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (in_item_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (out_item_o)
  );

  // No input is taken while a result is offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken during output");

  // A negative result is always a single final character.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.empty_res) |-> out_item_o.last)
    else $error("empty result not last");

  // The error flag never falls after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(out_item_o.error) |-> out_item_o.error) else $error("error flag cleared");

endmodule
